// ===== hw/rtl/ccfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ccfr_pkg: shared types and constants
// Status codes, controller states and the command/status structs between the
// controller and the datapath of the COBS/CRC frame receiver.
// ----------------------------------------------------------------------------
package ccfr_pkg;

  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_HELD     = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_COBS     = 3'd4;
  localparam logic [2:0] ST_CRC      = 3'd5;
  localparam logic [2:0] ST_HDR      = 3'd6;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  localparam logic [1:0] REG_MAGIC0  = 2'd0;
  localparam logic [1:0] REG_MAGIC1  = 2'd1;
  localparam logic [1:0] REG_VERSION = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FINISH,
    S_OUT
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_byte;   // decode one line byte
    logic drop_frame;  // discard current frame (overflow)
    logic finish;      // delimiter: run the final checks
    logic release_frm; // drop the held frame
    logic read_rd;     // issue payload read
    logic out_load;    // capture result
  } ccfr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic held;
    logic raw_empty;
    logic raw_full;
  } ccfr_sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/ccfr_ram.sv =====
// ----------------------------------------------------------------------------
// ccfr_ram: generic simple dual-port RAM
// One write and one read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module ccfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ccfr_datapath.sv =====
// ----------------------------------------------------------------------------
// ccfr_datapath: streaming COBS decode, CRC and frame hold
// Decodes each line byte as it arrives into the decoded RAM, runs the CRC two
// bytes behind, captures header bytes and holds the result registers.
// ----------------------------------------------------------------------------
module ccfr_datapath #(
  parameter int MAX_PAYLOAD_BYTES = 256,
  parameter int RAW_DEPTH         = 512,
  parameter int DECODED_DEPTH     = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ccfr_pkg::ccfr_cmd_t   cmd,
  output ccfr_pkg::ccfr_sts_t   sts,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            byte_index,
  input  logic [2:0]            ev_status,
  input  logic                  ev_accepted,
  output logic [2:0]            fin_status,
  output logic                  accepted,
  output logic [2:0]            status,
  output logic                  frame_ready,
  output logic [7:0]            frame_type,
  output logic [7:0]            frame_flags,
  output logic [15:0]           frame_seq,
  output logic [8:0]            frame_length,
  output logic [7:0]            read_data,
  output logic [31:0]           crc_error_count,
  output logic [31:0]           cobs_error_count,
  output logic [31:0]           header_error_count
);

  localparam int DAW = $clog2(DECODED_DEPTH);
  localparam int RCW = $clog2(RAW_DEPTH + 1);
  localparam int DCW = $clog2(DECODED_DEPTH + 1);
  localparam int HDR = 9;

  logic [7:0] magic0, magic1, version;
  logic [RCW-1:0] raw_count;
  logic [DCW-1:0] wr;          // decoded bytes written
  logic [7:0]     left;        // data bytes left in current block
  logic [7:0]     code;        // current block code
  logic           bad;         // decode failed
  logic [15:0]    crc;
  logic [7:0]     d1, d2;      // last two decoded bytes (d1 newest)
  logic [7:0]     hdr [HDR];
  logic           held;
  logic [7:0]     h_type, h_flags;
  logic [15:0]    h_seq;
  logic [8:0]     h_len;
  logic [31:0]    crc_errors, cobs_errors, header_errors;
  logic           rd_ok;
  logic [7:0]     rd_idx;      // payload position of the read in flight
  logic [7:0]     ram_q;

  // decoded RAM write side
  logic           we;
  logic [7:0]     wdata;
  logic           push0;       // pending block-end zero before this byte
  logic           push_n;      // data byte pushed this step

  ccfr_ram #(.WIDTH(8), .DEPTH(DECODED_DEPTH)) u_dec (
    .clk  (clk),
    .we   (we),
    .waddr(wr[DAW-1:0]),
    .wdata(wdata),
    .raddr(DAW'(HDR + int'(rd_idx))),
    .rdata(ram_q)
  );

  // a new block starts after a finished block; its implicit zero is written
  // when the next code arrives and more data follows
  always_comb begin
    push0  = 1'b0;
    push_n = 1'b0;
    we     = 1'b0;
    wdata  = rx_byte;
    if (cmd.take_byte && !bad) begin
      if (raw_count == '0 || left == 8'd0) begin
        // code byte: previous non-FF block ends with a zero
        push0 = (raw_count != '0) && (code != 8'hFF);
        we    = push0 && (wr < DCW'(DECODED_DEPTH));
        wdata = 8'h00;
      end else begin
        push_n = 1'b1;
        we     = wr < DCW'(DECODED_DEPTH);
      end
    end
  end

  assign sts.held      = held;
  assign sts.raw_empty = (raw_count == '0);
  assign sts.raw_full  = (raw_count >= RCW'(RAW_DEPTH));

  // final checks at the delimiter
  logic [15:0] got, plen;
  logic        dec_fail;
  always_comb begin
    got      = {d1, d2};
    plen     = {hdr[8], hdr[7]};
    dec_fail = bad || (left != 8'd0) || (wr < DCW'(HDR + 2));
    if (dec_fail) begin
      fin_status = ccfr_pkg::ST_COBS;
    end else if (got != crc) begin
      fin_status = ccfr_pkg::ST_CRC;
    end else if (hdr[0] != magic0 || hdr[1] != magic1 || hdr[2] != version) begin
      fin_status = ccfr_pkg::ST_HDR;
    end else if (plen > 16'(MAX_PAYLOAD_BYTES) ||
                 32'(wr) != 32'(HDR + 2) + 32'(plen)) begin
      fin_status = ccfr_pkg::ST_HDR;
    end else begin
      fin_status = ccfr_pkg::ST_OK;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      magic0  <= 8'd0;
      magic1  <= 8'd0;
      version <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ccfr_pkg::REG_MAGIC0:  magic0  <= cfg_data;
        ccfr_pkg::REG_MAGIC1:  magic1  <= cfg_data;
        ccfr_pkg::REG_VERSION: version <= cfg_data;
        default: ;
      endcase
    end
  end

  // decoder, CRC pipeline, held frame and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_count     <= '0;
      wr            <= '0;
      left          <= 8'd0;
      code          <= 8'd0;
      bad           <= 1'b0;
      crc           <= ccfr_pkg::CRC_INIT;
      held          <= 1'b0;
      h_type        <= 8'd0;
      h_flags       <= 8'd0;
      h_seq         <= 16'd0;
      h_len         <= 9'd0;
      crc_errors    <= '0;
      cobs_errors   <= '0;
      header_errors <= '0;
      rd_ok         <= 1'b0;
      rd_idx        <= 8'd0;
    end else begin
      if (cmd.take_byte) begin
        raw_count <= raw_count + RCW'(1);
        if (raw_count == '0 || left == 8'd0) begin
          code <= rx_byte;
          left <= rx_byte - 8'd1;
          if (push0) begin
            if (wr >= DCW'(DECODED_DEPTH)) bad <= 1'b1;
            else wr <= wr + DCW'(1);
          end
        end else begin
          left <= left - 8'd1;
          if (push_n && !bad) begin
            if (wr >= DCW'(DECODED_DEPTH)) bad <= 1'b1;
            else wr <= wr + DCW'(1);
          end
        end
      end
      if (cmd.drop_frame) begin
        raw_count   <= '0;
        cobs_errors <= cobs_errors + 32'd1;
        wr <= '0; left <= 8'd0; bad <= 1'b0; crc <= ccfr_pkg::CRC_INIT;
      end
      if (cmd.finish) begin
        raw_count <= '0;
        wr <= '0; left <= 8'd0; bad <= 1'b0; crc <= ccfr_pkg::CRC_INIT;
        case (fin_status)
          ccfr_pkg::ST_COBS: cobs_errors   <= cobs_errors + 32'd1;
          ccfr_pkg::ST_CRC:  crc_errors    <= crc_errors + 32'd1;
          ccfr_pkg::ST_HDR:  header_errors <= header_errors + 32'd1;
          ccfr_pkg::ST_OK: begin
            held    <= 1'b1;
            h_type  <= hdr[3];
            h_flags <= hdr[4];
            h_seq   <= {hdr[6], hdr[5]};
            h_len   <= plen[8:0];
          end
          default: ;
        endcase
      end
      if (cmd.release_frm) begin
        held <= 1'b0;
      end
      // latch the read position; clear the read flag once the result is out
      if (cmd.read_rd) begin
        rd_idx <= byte_index;
        rd_ok  <= held && (9'(byte_index) < h_len) &&
                  (HDR + int'(byte_index) < DECODED_DEPTH);
      end else if (cmd.out_load) begin
        rd_ok <= 1'b0;
      end
      // CRC runs on the byte leaving the two-byte delay line
      if (we && !cmd.drop_frame && !cmd.finish && wr >= DCW'(2)) begin
        crc <= ccfr_pkg::crc_byte(crc, d2);
      end
    end
  end

  // delay line and header capture
  always_ff @(posedge clk) begin
    if (we) begin
      d1 <= wdata;
      d2 <= d1;
      if (wr < DCW'(HDR)) begin
        hdr[wr[3:0]] <= wdata;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted <= 1'b0;
      status   <= ccfr_pkg::ST_NONE;
    end else if (cmd.out_load) begin
      accepted <= ev_accepted;
      status   <= ev_status;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      frame_ready        <= held;
      frame_type         <= held ? h_type : 8'd0;
      frame_flags        <= held ? h_flags : 8'd0;
      frame_seq          <= held ? h_seq : 16'd0;
      frame_length       <= held ? h_len : 9'd0;
      read_data          <= rd_ok ? ram_q : 8'd0;
      crc_error_count    <= crc_errors;
      cobs_error_count   <= cobs_errors;
      header_error_count <= header_errors;
    end
  end

endmodule

// ===== hw/rtl/ccfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ccfr_ctrl: item sequencer
// Accepts one item, issues datapath commands, presents the result and waits
// for it to be taken.
// ----------------------------------------------------------------------------
module ccfr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic [1:0]          kind,
  input  logic [7:0]          rx_byte,
  input  ccfr_pkg::ccfr_sts_t sts,
  input  logic [2:0]          fin_status,
  output ccfr_pkg::ccfr_cmd_t cmd,
  output logic [2:0]          ev_status,
  output logic                ev_accepted
);

  ccfr_pkg::ctrl_state_t state, state_next;
  logic [2:0] ev_st, ev_st_next;
  logic       ev_acc, ev_acc_next;
  logic       valid, valid_next;

  // state and event registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ccfr_pkg::S_IDLE;
      ev_st  <= ccfr_pkg::ST_NONE;
      ev_acc <= 1'b0;
      valid  <= 1'b0;
    end else begin
      state  <= state_next;
      ev_st  <= ev_st_next;
      ev_acc <= ev_acc_next;
      valid  <= valid_next;
    end
  end

  assign out_valid   = valid;
  assign ev_status   = ev_st;
  assign ev_accepted = ev_acc;
  assign in_ready    = (state == ccfr_pkg::S_IDLE) && (!valid || out_ready);

  // next state and commands
  always_comb begin
    state_next  = state;
    ev_st_next  = ev_st;
    ev_acc_next = ev_acc;
    valid_next  = valid && !out_ready;
    cmd         = '0;
    case (state)
      ccfr_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          ev_st_next  = ccfr_pkg::ST_NONE;
          ev_acc_next = 1'b0;
          state_next  = ccfr_pkg::S_OUT;
          case (kind)
            ccfr_pkg::KIND_BYTE: begin
              if (sts.held) begin
                ev_st_next  = ccfr_pkg::ST_HELD;
                ev_acc_next = 1'b1;
              end else if (rx_byte == 8'h00) begin
                if (!sts.raw_empty) state_next = ccfr_pkg::S_FINISH;
              end else if (sts.raw_full) begin
                cmd.drop_frame = 1'b1;
                ev_st_next     = ccfr_pkg::ST_OVERFLOW;
              end else begin
                cmd.take_byte = 1'b1;
              end
            end
            ccfr_pkg::KIND_RELEASE: cmd.release_frm = 1'b1;
            ccfr_pkg::KIND_READ: begin
              cmd.read_rd = 1'b1;
              state_next  = ccfr_pkg::S_READ;
            end
            default: ;
          endcase
        end
      end
      ccfr_pkg::S_READ: state_next = ccfr_pkg::S_OUT;
      ccfr_pkg::S_FINISH: begin
        cmd.finish  = 1'b1;
        ev_st_next  = fin_status;
        ev_acc_next = (fin_status == ccfr_pkg::ST_OK);
        state_next  = ccfr_pkg::S_OUT;
      end
      ccfr_pkg::S_OUT: begin
        cmd.out_load = 1'b1;
        valid_next   = 1'b1;
        state_next   = ccfr_pkg::S_IDLE;
      end
      default: state_next = ccfr_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/cobs_crc_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// cobs_crc_frame_receiver: COBS frame receiver with CRC-16-CCITT check
// Decodes COBS as bytes arrive, checks CRC and header at the delimiter and
// holds a good frame for indexed payload reads until released.
// ----------------------------------------------------------------------------
//  channel | signals                                   | role
//  in      | in_valid in_ready kind rx_byte byte_index | command items
//  out     | out_valid out_ready accepted status ...   | one result per item
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | register writes
//
// An item passes the accept and output states; a payload read adds a RAM read
// state, a frame-ending delimiter a final check state. A new item is taken
// only when no result waits or the waiting result is taken in the same cycle.
// Reset clears counters and the held frame; RAMs are not cleared.
module cobs_crc_frame_receiver #(
  parameter int MAX_PAYLOAD_BYTES = 256,
  parameter int RAW_DEPTH         = 512,
  parameter int DECODED_DEPTH     = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  byte_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic [2:0]  status,
  output logic        frame_ready,
  output logic [7:0]  frame_type,
  output logic [7:0]  frame_flags,
  output logic [15:0] frame_seq,
  output logic [8:0]  frame_length,
  output logic [7:0]  read_data,
  output logic [31:0] crc_error_count,
  output logic [31:0] cobs_error_count,
  output logic [31:0] header_error_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  ccfr_pkg::ccfr_cmd_t cmd;
  ccfr_pkg::ccfr_sts_t sts;
  logic [2:0] fin_status, ev_status;
  logic       ev_accepted;

  assign cfg_ready = 1'b1;

  ccfr_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .rx_byte(rx_byte),
    .sts(sts), .fin_status(fin_status), .cmd(cmd),
    .ev_status(ev_status), .ev_accepted(ev_accepted)
  );

  ccfr_datapath #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
    .RAW_DEPTH(RAW_DEPTH),
    .DECODED_DEPTH(DECODED_DEPTH)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .rx_byte(rx_byte), .byte_index(byte_index),
    .ev_status(ev_status), .ev_accepted(ev_accepted), .fin_status(fin_status),
    .accepted(accepted), .status(status), .frame_ready(frame_ready),
    .frame_type(frame_type), .frame_flags(frame_flags), .frame_seq(frame_seq),
    .frame_length(frame_length), .read_data(read_data),
    .crc_error_count(crc_error_count), .cobs_error_count(cobs_error_count),
    .header_error_count(header_error_count)
  );

endmodule
